FILE: src/tgrc_pkg.sv
// ---------------------------------------------------------------------------
// tgrc_pkg
// Shared types and constants of the tile grid rectangle collision unit.
// ---------------------------------------------------------------------------
package tgrc_pkg;

    localparam int TYPE_W     = 11;  // stored tile type
    localparam int COORD_W    = 6;   // tile_x / tile_y request fields
    localparam int RECT_W     = 16;  // rectangle edges and sizes
    localparam int SUM_W      = 17;  // edge plus size, divider dividend
    localparam int SIZE_W     = 9;   // tile width / height
    localparam int DIM_W      = 7;   // map_cols / map_rows and scan counters
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [TYPE_W-1:0] EMPTY_TYPE = {TYPE_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_QUERY = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_W   = 3'd0,
        REG_TILE_H   = 3'd1,
        REG_MAP_COLS = 3'd2,
        REG_MAP_ROWS = 3'd3
    } t_reg_idx;

    typedef struct packed {
        logic load;
        logic wr_tile;
        logic clear;
        logic rd_scan;
        logic res_mem;
        logic div_start;
        logic div_capture;
        logic setup;
        logic scan_adv;
        logic set_touch;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic div_done;
        logic div_last;
        logic range_empty;
        logic cell_full;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: src/tgrc_ifs.sv
// ---------------------------------------------------------------------------
// tgrc interfaces
// Request, result and register write channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface tgrc_req_if;
    import tgrc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               func;
    logic [COORD_W-1:0]       tile_x;
    logic [COORD_W-1:0]       tile_y;
    logic signed [TYPE_W-1:0] tile_type;
    logic [RECT_W-1:0]        rect_x;
    logic [RECT_W-1:0]        rect_y;
    logic [RECT_W-1:0]        rect_w;
    logic [RECT_W-1:0]        rect_h;
    modport source (output valid, func, tile_x, tile_y, tile_type,
                    rect_x, rect_y, rect_w, rect_h, input ready);
    modport sink   (input valid, func, tile_x, tile_y, tile_type,
                    rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface tgrc_res_if;
    import tgrc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [TYPE_W-1:0] read_type;
    logic                     touching;
    modport source (output valid, read_type, touching, input ready);
    modport sink   (input valid, read_type, touching, output ready);
endinterface

interface tgrc_cfg_if;
    import tgrc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/tgrc_div.sv
// ---------------------------------------------------------------------------
// tgrc_div
// Restoring divider, one quotient bit per cycle; a zero divisor acts as one.
// ---------------------------------------------------------------------------
module tgrc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tgrc_pkg::SUM_W-1:0]  i_dividend,
    input  logic [tgrc_pkg::SIZE_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [tgrc_pkg::SUM_W-1:0]  o_quot
);
    import tgrc_pkg::*;

    localparam int CW = $clog2(SUM_W);
    localparam logic [CW-1:0] CNT_LAST = CW'(SUM_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [SIZE_W-1:0] r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [SIZE_W-1:0] r_dvs;

    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   diff;
    logic              ge;
    logic [SIZE_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
        n_rem = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= (i_divisor == '0) ? SIZE_W'(1) : i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[SUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

FILE: src/tgrc_dp.sv
// ---------------------------------------------------------------------------
// tgrc_dp
// Datapath: registers, tile store, divider, scan counters and result stage.
// ---------------------------------------------------------------------------
module tgrc_dp #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tgrc_pkg::t_dp_cmd                  i_cmd,
    output tgrc_pkg::t_dp_stat                 o_stat,
    input  logic                               i_cfg_we,
    input  logic [tgrc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tgrc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [tgrc_pkg::COORD_W-1:0]       i_tile_x,
    input  logic [tgrc_pkg::COORD_W-1:0]       i_tile_y,
    input  logic signed [tgrc_pkg::TYPE_W-1:0] i_tile_type,
    input  logic [tgrc_pkg::RECT_W-1:0]        i_rect_x,
    input  logic [tgrc_pkg::RECT_W-1:0]        i_rect_y,
    input  logic [tgrc_pkg::RECT_W-1:0]        i_rect_w,
    input  logic [tgrc_pkg::RECT_W-1:0]        i_rect_h,
    input  logic                               i_res_ready,
    output logic                               o_res_valid,
    output logic signed [tgrc_pkg::TYPE_W-1:0] o_read_type,
    output logic                               o_touching
);
    import tgrc_pkg::*;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = 2 * DIM_W + 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    // configuration
    logic [SIZE_W-1:0] r_tile_w;
    logic [SIZE_W-1:0] r_tile_h;
    logic [DIM_W-1:0]  r_map_cols;
    logic [DIM_W-1:0]  r_map_rows;
    logic [DIM_W-1:0]  cols;
    logic [DIM_W-1:0]  rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_w   <= SIZE_W'(32);
            r_tile_h   <= SIZE_W'(32);
            r_map_cols <= DIM_W'(64);
            r_map_rows <= DIM_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TILE_W:   r_tile_w   <= i_cfg_data;
                REG_TILE_H:   r_tile_h   <= i_cfg_data;
                REG_MAP_COLS: r_map_cols <= i_cfg_data[DIM_W-1:0];
                REG_MAP_ROWS: r_map_rows <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate the map size to 1..MAX
    always_comb begin
        if (r_map_cols == '0) begin
            cols = DIM_W'(1);
        end else if (int'(r_map_cols) > MAX_COLS) begin
            cols = DIM_W'(MAX_COLS);
        end else begin
            cols = r_map_cols;
        end
        if (r_map_rows == '0) begin
            rows = DIM_W'(1);
        end else if (int'(r_map_rows) > MAX_ROWS) begin
            rows = DIM_W'(MAX_ROWS);
        end else begin
            rows = r_map_rows;
        end
    end

    // request address for write / read
    logic              in_inmap;
    logic [PW-1:0]     in_sum;
    logic [AW-1:0]     in_addr;

    always_comb begin
        in_inmap = ({1'b0, i_tile_x} < cols) && ({1'b0, i_tile_y} < rows);
        in_sum   = PW'(i_tile_y) * PW'(cols) + PW'(i_tile_x);
        in_addr  = AW'(in_sum);
    end

    // latched request
    logic              r_inmap;
    logic [RECT_W-1:0] r_rect_x;
    logic [RECT_W-1:0] r_rect_y;
    logic [RECT_W-1:0] r_rect_w;
    logic [RECT_W-1:0] r_rect_h;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_inmap  <= in_inmap;
            r_rect_x <= i_rect_x;
            r_rect_y <= i_rect_y;
            r_rect_w <= i_rect_w;
            r_rect_h <= i_rect_h;
        end
    end

    // edge division: x0, x1, y0, y1 in turn through one divider
    logic [1:0]        r_div_sel;
    logic [SUM_W-1:0]  r_quot [4];
    logic [SUM_W-1:0]  div_dividend;
    logic [SIZE_W-1:0] div_divisor;
    logic              div_done;
    logic [SUM_W-1:0]  div_quot;

    always_comb begin
        case (r_div_sel)
            2'd0:    div_dividend = SUM_W'(r_rect_x);
            2'd1:    div_dividend = SUM_W'(r_rect_x) + SUM_W'(r_rect_w);
            2'd2:    div_dividend = SUM_W'(r_rect_y);
            default: div_dividend = SUM_W'(r_rect_y) + SUM_W'(r_rect_h);
        endcase
        div_divisor = r_div_sel[1] ? r_tile_h : r_tile_w;
    end

    tgrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_sel <= '0;
        end else if (i_cmd.load) begin
            r_div_sel <= '0;
        end else if (i_cmd.div_capture) begin
            r_div_sel <= r_div_sel + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_capture) begin
            r_quot[r_div_sel] <= div_quot;
        end
    end

    // clamp the far edges to the map and set up the scan
    logic [DIM_W-1:0] x1c;
    logic [DIM_W-1:0] y1c;
    logic             range_empty;

    always_comb begin
        x1c = (r_quot[1] >= SUM_W'(cols)) ? cols - 1'b1 : r_quot[1][DIM_W-1:0];
        y1c = (r_quot[3] >= SUM_W'(rows)) ? rows - 1'b1 : r_quot[3][DIM_W-1:0];
        range_empty = (r_quot[0] > SUM_W'(x1c)) || (r_quot[2] > SUM_W'(y1c));
    end

    logic [DIM_W-1:0] r_x;
    logic [DIM_W-1:0] r_y;
    logic [DIM_W-1:0] r_y0;
    logic [DIM_W-1:0] r_x1;
    logic [DIM_W-1:0] r_y1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_x  <= r_quot[0][DIM_W-1:0];
            r_y  <= r_quot[2][DIM_W-1:0];
            r_y0 <= r_quot[2][DIM_W-1:0];
            r_x1 <= x1c;
            r_y1 <= y1c;
        end else if (i_cmd.scan_adv) begin
            // column by column, rows inside
            if (r_y == r_y1) begin
                r_y <= r_y0;
                r_x <= r_x + 1'b1;
            end else begin
                r_y <= r_y + 1'b1;
            end
        end
    end

    logic [PW-1:0] scan_sum;
    logic [AW-1:0] scan_addr;

    always_comb begin
        scan_sum  = PW'(r_y) * PW'(cols) + PW'(r_x);
        scan_addr = AW'(scan_sum);
    end

    // tile store
    logic [TYPE_W-1:0] r_mem [DEPTH];
    logic [TYPE_W-1:0] r_mem_q;
    logic [AW-1:0]     r_clr_addr;
    logic [AW-1:0]     rd_addr;

    assign rd_addr = i_cmd.rd_scan ? scan_addr : in_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[r_clr_addr] <= EMPTY_TYPE;
        end else if (i_cmd.wr_tile && in_inmap) begin
            r_mem[in_addr] <= i_tile_type;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    // result and output register
    logic [TYPE_W-1:0] r_res_type;
    logic              r_res_touch;
    logic              r_out_valid;
    logic [TYPE_W-1:0] r_out_type;
    logic              r_out_touch;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res_type  <= EMPTY_TYPE;
            r_res_touch <= 1'b0;
        end else begin
            if (i_cmd.res_mem) begin
                r_res_type <= r_inmap ? r_mem_q : EMPTY_TYPE;
            end
            if (i_cmd.set_touch) begin
                r_res_touch <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_type  <= r_res_type;
            r_out_touch <= r_res_touch;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_read_type = r_out_type;
    assign o_touching  = r_out_touch;

    always_comb begin
        o_stat.clear_last  = (r_clr_addr == CLR_LAST);
        o_stat.div_done    = div_done;
        o_stat.div_last    = (r_div_sel == 2'd3);
        o_stat.range_empty = range_empty;
        o_stat.cell_full   = !r_mem_q[TYPE_W-1];
        o_stat.scan_last   = (r_x == r_x1) && (r_y == r_y1);
        o_stat.out_free    = !r_out_valid || i_res_ready;
    end

endmodule

FILE: src/tgrc_ctrl.sv
// ---------------------------------------------------------------------------
// tgrc_ctrl
// Controller: sequences clear pass, tile access, divisions and cell scan.
// ---------------------------------------------------------------------------
module tgrc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic [1:0]          i_req_func,
    input  tgrc_pkg::t_dp_stat  i_stat,
    output logic                o_req_ready,
    output tgrc_pkg::t_dp_cmd   o_cmd
);
    import tgrc_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_MEM      = 9'b000000100,
        S_DIV_GO   = 9'b000001000,
        S_DIV_WAIT = 9'b000010000,
        S_SETUP    = 9'b000100000,
        S_SCAN_RD  = 9'b001000000,
        S_SCAN_CHK = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_req_func)
                        FUNC_WRITE: begin
                            o_cmd.wr_tile = 1'b1;
                            n_state       = S_DONE;
                        end
                        FUNC_READ:  n_state = S_MEM;
                        FUNC_QUERY: n_state = S_DIV_GO;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_MEM: begin
                o_cmd.res_mem = 1'b1;
                n_state       = S_DONE;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.div_capture = 1'b1;
                    n_state = i_stat.div_last ? S_SETUP : S_DIV_GO;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = i_stat.range_empty ? S_DONE : S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                // stop at the first occupied cell
                if (i_stat.cell_full) begin
                    o_cmd.set_touch = 1'b1;
                    n_state         = S_DONE;
                end else if (i_stat.scan_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: src/tile_grid_rect_collision_unit.sv
// Write stores the tile as the request is taken; read samples the store at that
// point and latches the type in S_MEM; both register the result in S_DONE. Query:
// four 17-bit edge divisions in turn through one bit-serial divider, then a read and a check per cell.
// One request at a time; the next request is taken while a result waits.
// Reset: synchronous; a clear pass over all MAX_COLS * MAX_ROWS cells (4096 by
// default) empties the tile store, requests are held off until it ends.
// ---------------------------------------------------------------------------
// tile_grid_rect_collision_unit
// Tile map with write, read and rectangle touch query requests.
// ---------------------------------------------------------------------------
module tile_grid_rect_collision_unit #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tgrc_cfg_if.sink   i_cfg,
    tgrc_req_if.sink   i_req,
    tgrc_res_if.source o_res
);
    import tgrc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     req_ready;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = req_ready;

    tgrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .i_stat      (stat),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    tgrc_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg.valid && i_cfg.ready),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_tile_x    (i_req.tile_x),
        .i_tile_y    (i_req.tile_y),
        .i_tile_type (i_req.tile_type),
        .i_rect_x    (i_req.rect_x),
        .i_rect_y    (i_req.rect_y),
        .i_rect_w    (i_req.rect_w),
        .i_rect_h    (i_req.rect_h),
        .i_res_ready (o_res.ready),
        .o_res_valid (o_res.valid),
        .o_read_type (o_res.read_type),
        .o_touching  (o_res.touching)
    );

endmodule

FILE: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tile grid rectangle collision unit. A model of
// the tile map predicts every result. Directed requests cover the corners
// first. Random requests follow under several map and tile sizes, with random
// gaps on the request channel and back-pressure on the result channel.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tgrc_pkg::*;

    localparam int CLK_PERIOD        = 10;
    localparam int RESET_CYCLES      = 11;
    localparam int MAP_MAX_COLS      = 64;
    localparam int MAP_MAX_ROWS      = 64;
    localparam int MAP_DEPTH         = MAP_MAX_COLS * MAP_MAX_ROWS;
    localparam int ITEMS_PER_SEGMENT = 200;
    // leave wide margin over a full-map scan and the clear pass
    localparam int STALL_LIMIT       = 50000;
    localparam int SETTLE_CYCLES     = 16;
    localparam int MAX_REPORTS       = 100;

    localparam logic [1:0]           FUNC_NOP  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;

    typedef struct {
        logic [1:0]               func;
        logic [COORD_W-1:0]       tile_x;
        logic [COORD_W-1:0]       tile_y;
        logic signed [TYPE_W-1:0] tile_type;
        logic [RECT_W-1:0]        rect_x;
        logic [RECT_W-1:0]        rect_y;
        logic [RECT_W-1:0]        rect_w;
        logic [RECT_W-1:0]        rect_h;
    } t_tile_request;

    typedef struct {
        logic signed [TYPE_W-1:0] read_type;
        logic                     touching;
    } t_tile_result;

    class tile_map_scoreboard;
        logic [TYPE_W-1:0] cells [MAP_DEPTH];
        logic [SIZE_W-1:0] tile_w_reg;
        logic [SIZE_W-1:0] tile_h_reg;
        logic [DIM_W-1:0]  cols_reg;
        logic [DIM_W-1:0]  rows_reg;
        t_tile_result      results_due [$];
        int                errors;

        function new();
            foreach (cells[i]) cells[i] = EMPTY_TYPE;
            tile_w_reg = 9'd32;
            tile_h_reg = 9'd32;
            cols_reg   = 7'd64;
            rows_reg   = 7'd64;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_TILE_W:   tile_w_reg = val[SIZE_W-1:0];
                REG_TILE_H:   tile_h_reg = val[SIZE_W-1:0];
                REG_MAP_COLS: cols_reg   = val[DIM_W-1:0];
                REG_MAP_ROWS: rows_reg   = val[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned cols_in_use();
            if (cols_reg == 0) return 1;
            if (cols_reg > MAP_MAX_COLS) return MAP_MAX_COLS;
            return cols_reg;
        endfunction

        function int unsigned rows_in_use();
            if (rows_reg == 0) return 1;
            if (rows_reg > MAP_MAX_ROWS) return MAP_MAX_ROWS;
            return rows_reg;
        endfunction

        function int unsigned tile_w_in_use();
            return (tile_w_reg == 0) ? 1 : tile_w_reg;
        endfunction

        function int unsigned tile_h_in_use();
            return (tile_h_reg == 0) ? 1 : tile_h_reg;
        endfunction

        function void note_request(t_tile_request r);
            int unsigned  cols, rows, tw, th, x0, x1, y0, y1, x, y;
            t_tile_result res;
            cols = cols_in_use();
            rows = rows_in_use();
            tw   = tile_w_in_use();
            th   = tile_h_in_use();
            res.read_type = EMPTY_TYPE;
            res.touching  = 1'b0;
            case (r.func)
                FUNC_WRITE: begin
                    if (r.tile_x < cols && r.tile_y < rows)
                        cells[r.tile_y * cols + r.tile_x] = r.tile_type;
                end
                FUNC_READ: begin
                    if (r.tile_x < cols && r.tile_y < rows)
                        res.read_type = cells[r.tile_y * cols + r.tile_x];
                end
                FUNC_QUERY: begin
                    x0 = 32'(r.rect_x) / tw;
                    x1 = (32'(r.rect_x) + 32'(r.rect_w)) / tw;
                    y0 = 32'(r.rect_y) / th;
                    y1 = (32'(r.rect_y) + 32'(r.rect_h)) / th;
                    // cells past the map edge count as empty
                    if (x1 >= cols) x1 = cols - 1;
                    if (y1 >= rows) y1 = rows - 1;
                    for (x = x0; x <= x1 && !res.touching; x++)
                        for (y = y0; y <= y1 && !res.touching; y++)
                            if (!cells[y * cols + x][TYPE_W-1]) res.touching = 1'b1;
                end
                default: ;
            endcase
            results_due = {results_due, res};
        endfunction

        task report(string msg);
            if (errors < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic signed [TYPE_W-1:0] got_type, logic got_touch);
            t_tile_result want;
            if (results_due.size() == 0) begin
                report("result with no request outstanding");
                return;
            end
            want = results_due.pop_front();
            if (got_type !== want.read_type)
                report($sformatf("read_type %0d, expected %0d", got_type, want.read_type));
            if (got_touch !== want.touching)
                report($sformatf("touching %b, expected %b", got_touch, want.touching));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   quiet_cycles = 0;

    tile_map_scoreboard sb = new();

    tgrc_cfg_if cfg_ch ();
    tgrc_req_if req_ch ();
    tgrc_res_if res_ch ();

    tile_grid_rect_collision_unit #(
        .MAX_COLS (MAP_MAX_COLS),
        .MAX_ROWS (MAP_MAX_ROWS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.read_type, res_ch.touching);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[tile_grid_rect_collision_unit] ERROR");
                $finish;
            end
        end
    end

    function automatic t_tile_request tile_op(logic [1:0] func, int x, int y, int kind,
                                              int rx, int ry, int rw, int rh);
        t_tile_request r;
        r.func      = func;
        r.tile_x    = COORD_W'(x);
        r.tile_y    = COORD_W'(y);
        r.tile_type = TYPE_W'(kind);
        r.rect_x    = RECT_W'(rx);
        r.rect_y    = RECT_W'(ry);
        r.rect_w    = RECT_W'(rw);
        r.rect_h    = RECT_W'(rh);
        return r;
    endfunction

    function automatic t_tile_request random_request();
        t_tile_request r;
        int unsigned   cols, rows, tw, th, pick, span;
        cols = sb.cols_in_use();
        rows = sb.rows_in_use();
        tw   = sb.tile_w_in_use();
        th   = sb.tile_h_in_use();
        r.func      = FUNC_NOP;
        r.tile_x    = COORD_W'($urandom);
        r.tile_y    = COORD_W'($urandom);
        r.tile_type = TYPE_W'($urandom);
        r.rect_x    = RECT_W'($urandom);
        r.rect_y    = RECT_W'($urandom);
        r.rect_w    = RECT_W'($urandom);
        r.rect_h    = RECT_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 35) r.func = FUNC_WRITE;
        else if (pick < 60) r.func = FUNC_READ;
        else if (pick < 95) r.func = FUNC_QUERY;
        if (r.func == FUNC_WRITE || r.func == FUNC_READ) begin
            // mostly land inside the map so that writes stick
            if ($urandom_range(99) < 85) begin
                r.tile_x = COORD_W'($urandom_range(cols - 1));
                r.tile_y = COORD_W'($urandom_range(rows - 1));
            end
            pick = $urandom_range(99);
            if (pick < 50) r.tile_type = TYPE_W'($urandom_range(1023));
            else if (pick < 80) r.tile_type = EMPTY_TYPE;
        end else if (r.func == FUNC_QUERY && $urandom_range(99) < 90) begin
            // small rectangles over the map area keep scans short
            span = cols * tw + tw;
            if (span > 65535) span = 65535;
            r.rect_x = RECT_W'($urandom_range(span));
            r.rect_w = RECT_W'($urandom_range(2 * tw));
            span = rows * th + th;
            if (span > 65535) span = 65535;
            r.rect_y = RECT_W'($urandom_range(span));
            r.rect_h = RECT_W'($urandom_range(2 * th));
        end
        return r;
    endfunction

    task automatic send_request(input t_tile_request r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.func      <= r.func;
        req_ch.tile_x    <= r.tile_x;
        req_ch.tile_y    <= r.tile_y;
        req_ch.tile_type <= r.tile_type;
        req_ch.rect_x    <= r.rect_x;
        req_ch.rect_y    <= r.rect_y;
        req_ch.rect_w    <= r.rect_w;
        req_ch.rect_h    <= r.rect_h;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sb.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        sb.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        while (sb.results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_segment(input logic [CFG_DATA_W-1:0] tw, input logic [CFG_DATA_W-1:0] th,
                               input logic [CFG_DATA_W-1:0] cols,
                               input logic [CFG_DATA_W-1:0] rows);
        wait_idle();
        write_reg(REG_TILE_W, tw);
        write_reg(REG_TILE_H, th);
        write_reg(REG_MAP_COLS, cols);
        write_reg(REG_MAP_ROWS, rows);
        cfg_ch.valid <= 1'b0;
        repeat (ITEMS_PER_SEGMENT) send_request(random_request());
        req_ch.valid <= 1'b0;
    endtask

    task automatic run_directed();
        // empty map after reset, corners and a full-map scan
        send_request(tile_op(FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
        send_request(tile_op(FUNC_READ, 63, 63, 0, 0, 0, 0, 0));
        send_request(tile_op(FUNC_QUERY, 0, 0, 0, 0, 0, 65535, 65535));
        send_request(tile_op(FUNC_WRITE, 0, 0, 0, 0, 0, 0, 0));
        send_request(tile_op(FUNC_WRITE, 63, 63, 1023, 0, 0, 0, 0));
        send_request(tile_op(FUNC_WRITE, 5, 7, -1024, 0, 0, 0, 0));
        send_request(tile_op(FUNC_WRITE, 6, 7, -2, 0, 0, 0, 0));
        send_request(tile_op(FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
        send_request(tile_op(FUNC_READ, 63, 63, 0, 0, 0, 0, 0));
        send_request(tile_op(FUNC_READ, 5, 7, 0, 0, 0, 0, 0));
        send_request(tile_op(FUNC_READ, 6, 7, 0, 0, 0, 0, 0));
        // negative types never touch
        send_request(tile_op(FUNC_QUERY, 0, 0, 0, 160, 224, 63, 31));
        send_request(tile_op(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0));
        // far edge is inclusive; one unit short misses
        send_request(tile_op(FUNC_QUERY, 0, 0, 0, 1984, 1984, 32, 32));
        send_request(tile_op(FUNC_QUERY, 0, 0, 0, 1983, 1983, 0, 0));
        send_request(tile_op(FUNC_QUERY, 0, 0, 0, 65535, 65535, 65535, 65535));
        send_request(tile_op(FUNC_QUERY, 0, 0, 0, 2016, 2016, 65535, 65535));
        send_request(tile_op(FUNC_NOP, 63, 63, -1, 65535, 65535, 65535, 65535));
        send_request(tile_op(FUNC_WRITE, 0, 0, -1, 0, 0, 0, 0));
        send_request(tile_op(FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
        send_request(tile_op(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0));
        req_ch.valid <= 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_TILE_W;
        cfg_ch.data      = '0;
        req_ch.valid     = 1'b0;
        req_ch.func      = FUNC_WRITE;
        req_ch.tile_x    = '0;
        req_ch.tile_y    = '0;
        req_ch.tile_type = '0;
        req_ch.rect_x    = '0;
        req_ch.rect_y    = '0;
        req_ch.rect_w    = '0;
        req_ch.rect_h    = '0;
        res_ch.ready     = 1'b0;
        src_idle_pct     = 21;
        snk_idle_pct     = 76;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_segment(9'd16, 9'd8, 9'd40, 9'd24);
        run_segment(9'd1, 9'd1, 9'd64, 9'd64);

        src_idle_pct = 76;
        snk_idle_pct = 21;
        run_segment(9'd256, 9'd256, 9'd1, 9'd1);
        // zero tile size and out-of-range map size
        run_segment(9'd0, 9'd511, 9'd0, 9'd127);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_segment(CFG_DATA_W'($urandom_range(511)), CFG_DATA_W'($urandom_range(511)),
                    CFG_DATA_W'($urandom_range(64, 1)), CFG_DATA_W'($urandom_range(64, 1)));
        wait_idle();
        write_reg(REG_SPARE, 9'h1AA);
        cfg_ch.valid <= 1'b0;
        // upper data bits drop on the 7-bit map size registers
        run_segment(9'd32, 9'd32, 9'h1C5, 9'h140);

        wait_idle();
        if (sb.errors == 0) begin
            $display("[tile_grid_rect_collision_unit] OK");
        end else begin
            $display("[tile_grid_rect_collision_unit] ERROR");
        end
        $finish;
    end

endmodule
